[rtl/core/pireg_pkg.sv]
// Package for the PI position regulator: field widths, loop mode codes,
// register indexes and the configuration struct.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package pireg_pkg;

  localparam int POS_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int SUM_W   = 32;
  localparam int POWER_W = 16;
  localparam int SHIFT_W = 4;
  localparam int MODE_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  // Loop mode codes. The unused code behaves like proportional only.
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_P   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PI  = 2'd2;

  // Register indexes, decoded from paddr[4:2].
  localparam logic [IDX_W-1:0] REG_LOOP_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_INVERT     = 3'd3;
  localparam logic [IDX_W-1:0] REG_POWER_SHFT = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]        loop_mode;
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic                     invert_output;
    logic [SHIFT_W-1:0]       power_shift;
  } pireg_cfg_t;

endpackage

[rtl/core/pireg_if.sv]
// Handshake interfaces for the position regulator: the tick channel in
// and the drive channel out. Depends on pireg_pkg for the field widths.
`timescale 1ns / 1ps

interface pireg_in_if;
  import pireg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] encoder_pos;
  logic signed [POS_W-1:0] target_pos;

  modport source (output valid, output encoder_pos, output target_pos, input ready);
  modport sink   (input valid, input encoder_pos, input target_pos, output ready);
endinterface

interface pireg_out_if;
  import pireg_pkg::*;

  logic               valid;
  logic               ready;
  logic               drive_dir;
  logic [POWER_W-1:0] drive_power;

  modport source (output valid, output drive_dir, output drive_power, input ready);
  modport sink   (input valid, input drive_dir, input drive_power, output ready);
endinterface

[rtl/core/pi_position_regulator.sv]
// Top level of the PI position regulator: pipeline from the tick channel
// to the drive channel. Depends on pireg_pkg, pireg_if and pireg_apb.
`timescale 1ns / 1ps

// Usage:
// Each item on the sample channel is one control tick carrying the encoder
// position and the setpoint. The block filters the setpoint into a smoothed
// reference, forms the position error and its integral, and returns one
// item on the drive channel with a direction bit and a power magnitude.
// In loop mode 0 the state still advances but no drive item is produced.
// A tick passes the input, error, product and output registers. Throughput
// is one item per cycle while the receiver takes items; the reference and
// integral update of one tick fits in the single stage behind the input
// register, so ticks may arrive back to back. When the receiver stalls, the
// pipeline stages fill up one by one and sample.ready drops only once all
// stages and the output register hold items. Reset clears the pipeline,
// the reference and the integral, and sets the registers to mode 2 with
// zero gains, no inversion and no shift. The user must write registers over
// APB only while no tick is in flight; the block itself does not enforce it.
module pi_position_regulator (
  input  logic                         clk,
  input  logic                         rst,
  pireg_in_if.sink                     sample,
  pireg_out_if.source                  drive,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pireg_pkg::ADDR_W-1:0] paddr,
  input  logic [pireg_pkg::DATA_W-1:0] pwdata,
  output logic [pireg_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import pireg_pkg::*;

  pireg_cfg_t cfg;

  pireg_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage valid bits and the advance conditions, from the output backward.
  logic v1, v2, v3;
  logic r0, r1, r2, r3;

  assign r3 = !drive.valid || drive.ready;
  assign r2 = !v3 || r3;
  assign r1 = !v2 || r2;
  assign r0 = !v1 || r1;
  assign sample.ready = r0;

  // Stage 1: input register.
  logic signed [POS_W-1:0] pos1, tgt1;

  // Loop state.
  logic signed [POS_W-1:0] smoothed_ref, smoothed_ref_next;
  logic [SUM_W-1:0]        err_sum, err_sum_next;

  // Reference prefilter and error.
  logic signed [POS_W:0]   gap;
  logic [POS_W:0]          gap_abs;
  logic [POS_W-1:0]        step;
  logic signed [POS_W:0]   err;

  always_comb begin
    gap     = {tgt1[POS_W-1], tgt1} - {smoothed_ref[POS_W-1], smoothed_ref};
    gap_abs = gap[POS_W] ? (~gap + 1'b1) : gap;
    step    = POS_W'(gap_abs[POS_W:4]);
    if (step == '0) begin
      smoothed_ref_next = tgt1;
    end else if (gap[POS_W]) begin
      smoothed_ref_next = smoothed_ref - step;
    end else begin
      smoothed_ref_next = smoothed_ref + step;
    end
    err = {pos1[POS_W-1], pos1} - {smoothed_ref_next[POS_W-1], smoothed_ref_next};
    if (cfg.loop_mode == MODE_PI) begin
      err_sum_next = err_sum + {{(SUM_W-POS_W-1){err[POS_W]}}, err};
    end else begin
      err_sum_next = '0;
    end
  end

  // Stage 2: error and integral waiting for the multipliers.
  logic signed [POS_W:0]   err2;
  logic signed [SUM_W-1:0] sum2;

  logic signed [POS_W+GAIN_W:0]   prod_p_full;
  logic signed [SUM_W+GAIN_W-1:0] prod_i_full;

  assign prod_p_full = cfg.prop_gain * err2;
  assign prod_i_full = cfg.integ_gain * sum2;

  // Stage 3: both products, wrapped to 32 bits.
  logic [SUM_W-1:0] prod_p3, prod_i3;

  logic [SUM_W-1:0]        u_raw;
  logic signed [SUM_W-1:0] u_shr;
  logic [SUM_W-1:0]        u;
  logic [SUM_W-1:0]        mag;
  logic [POWER_W-1:0]      power;

  always_comb begin
    u_raw = prod_p3 + prod_i3;
    u_shr = $signed(u_raw) >>> 3;
    u     = cfg.invert_output ? (~u_shr + 1'b1) : u_shr;
    mag   = u[SUM_W-1] ? (~u + 1'b1) : u;
    power = mag[POWER_W-1:0] >> cfg.power_shift;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      drive.valid  <= 1'b0;
      smoothed_ref <= '0;
      err_sum      <= '0;
    end else begin
      if (r0) begin
        v1 <= sample.valid;
      end
      if (r1) begin
        v2 <= v1;
      end
      if (r2) begin
        v3 <= v2;
      end
      if (r3) begin
        drive.valid <= v3 && (cfg.loop_mode != MODE_OFF);
      end
      if (v1 && r1) begin
        smoothed_ref <= smoothed_ref_next;
        err_sum      <= err_sum_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (r0 && sample.valid) begin
      pos1 <= sample.encoder_pos;
      tgt1 <= sample.target_pos;
    end
    if (r1 && v1) begin
      err2 <= err;
      sum2 <= err_sum_next;
    end
    if (r2 && v2) begin
      prod_p3 <= prod_p_full[SUM_W-1:0];
      prod_i3 <= prod_i_full[SUM_W-1:0];
    end
    if (r3 && v3) begin
      drive.drive_dir   <= u[SUM_W-1];
      drive.drive_power <= power;
    end
  end

`ifndef SYNTHESIS
  // Reset empties every stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3 && !drive.valid))
    else $error("pipeline not empty after reset");

  // Outside mode 2 an advancing tick leaves the integral cleared.
  a_integral_cleared: assert property (@(posedge clk) disable iff (rst)
    (v1 && r1 && cfg.loop_mode != MODE_PI) |=> (err_sum == '0))
    else $error("integral not cleared outside PI mode");

  // Backpressure reaches the input only with every stage occupied.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (v1 && v2 && v3 && drive.valid && !drive.ready))
    else $error("input stalled with a free stage");

  // A new drive item comes only from an item in the last stage.
  a_out_from_stage3: assert property (@(posedge clk) disable iff (rst)
    $rose(drive.valid) |-> $past(v3))
    else $error("drive item without a source item");
`endif

endmodule

[rtl/core/pireg_apb.sv]
// APB register file of the position regulator: holds the loop mode, the
// gains, the output inversion and the power shift. Depends on pireg_pkg.
`timescale 1ns / 1ps

module pireg_apb (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pireg_pkg::ADDR_W-1:0]   paddr,
  input  logic [pireg_pkg::DATA_W-1:0]   pwdata,
  output logic [pireg_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output pireg_pkg::pireg_cfg_t          cfg
);
  import pireg_pkg::*;

  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_mode     <= MODE_PI;
      cfg.prop_gain     <= '0;
      cfg.integ_gain    <= '0;
      cfg.invert_output <= 1'b0;
      cfg.power_shift   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_LOOP_MODE:  cfg.loop_mode     <= pwdata[MODE_W-1:0];
        REG_PROP_GAIN:  cfg.prop_gain     <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg.integ_gain    <= pwdata[GAIN_W-1:0];
        REG_INVERT:     cfg.invert_output <= pwdata[0];
        REG_POWER_SHFT: cfg.power_shift   <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_LOOP_MODE:  prdata[MODE_W-1:0]  = cfg.loop_mode;
      REG_PROP_GAIN:  prdata[GAIN_W-1:0]  = cfg.prop_gain;
      REG_INTEG_GAIN: prdata[GAIN_W-1:0]  = cfg.integ_gain;
      REG_INVERT:     prdata[0]           = cfg.invert_output;
      REG_POWER_SHFT: prdata[SHIFT_W-1:0] = cfg.power_shift;
      default:        prdata = '0;
    endcase
  end

endmodule
